// ===== rtl/bic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bic_pkg;

    // Fixed field widths of the request and response beats.
    localparam int IRQ_W      = 7;
    localparam int RAW_W      = 32;
    localparam int RAW_IDX_W  = $clog2(RAW_W);
    localparam int BASIC_RAW_W = 8;
    localparam int OP_W       = 2;
    localparam int ID_W       = 7;

    // Defaults for the bank size parameters of the top level.
    localparam int DEFAULT_BANK_WIDTH  = 32;
    localparam int DEFAULT_BASIC_WIDTH = 8;

    typedef enum logic [OP_W-1:0] {
        OP_ENABLE  = 2'd0,
        OP_DISABLE = 2'd1,
        OP_QUERY   = 2'd2
    } op_t;

    // One request beat as held in the input register.
    typedef struct packed {
        logic [OP_W-1:0]        operation;
        logic [IRQ_W-1:0]       irq_number;
        logic [RAW_W-1:0]       raw_lines_bank1;
        logic [RAW_W-1:0]       raw_lines_bank2;
        logic [BASIC_RAW_W-1:0] raw_lines_basic;
    } req_t;

    // Enable bit update handed to the enable register file.
    typedef struct packed {
        logic             fire;
        logic             set;
        logic [IRQ_W-1:0] irq_number;
    } upd_t;

    // One response beat.
    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] source_id;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/bic_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bic_req_if;
    logic                               valid;
    logic                               ready;
    logic [bic_pkg::OP_W-1:0]           operation;
    logic [bic_pkg::IRQ_W-1:0]          irq_number;
    logic [bic_pkg::RAW_W-1:0]          raw_lines_bank1;
    logic [bic_pkg::RAW_W-1:0]          raw_lines_bank2;
    logic [bic_pkg::BASIC_RAW_W-1:0]    raw_lines_basic;

    modport source (
        output valid, operation, irq_number, raw_lines_bank1, raw_lines_bank2,
               raw_lines_basic,
        input  ready
    );

    modport sink (
        input  valid, operation, irq_number, raw_lines_bank1, raw_lines_bank2,
               raw_lines_basic,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/bic_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bic_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [bic_pkg::ID_W-1:0]   source_id;

    modport source (
        output valid, found, source_id,
        input  ready
    );

    modport sink (
        input  valid, found, source_id,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/bic_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input register: takes a request beat whenever it is empty or its
// current beat moves on in the same cycle.
module bic_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    bic_req_if.sink         req,
    input  wire logic       advance,
    output logic            valid,
    output bic_pkg::req_t   item
);

    logic          valid_reg;
    logic          valid_next;
    bic_pkg::req_t item_reg;
    logic          take;

    assign req.ready = !valid_reg || advance;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.operation       <= req.operation;
            item_reg.irq_number      <= req.irq_number;
            item_reg.raw_lines_bank1 <= req.raw_lines_bank1;
            item_reg.raw_lines_bank2 <= req.raw_lines_bank2;
            item_reg.raw_lines_basic <= req.raw_lines_basic;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

`default_nettype wire

// ===== rtl/bic_enable_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Enable masks of the three banks with single-bit set and clear.
module bic_enable_regs #(
    parameter int BANK_WIDTH  = bic_pkg::DEFAULT_BANK_WIDTH,
    parameter int BASIC_WIDTH = bic_pkg::DEFAULT_BASIC_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire bic_pkg::upd_t          upd,
    output logic [BANK_WIDTH-1:0]       mask_bank1,
    output logic [BANK_WIDTH-1:0]       mask_bank2,
    output logic [BASIC_WIDTH-1:0]      mask_basic
);

    localparam int BIT_W       = $clog2(BANK_WIDTH);
    localparam int BASIC_BIT_W = (BASIC_WIDTH > 1) ? $clog2(BASIC_WIDTH) : 1;
    localparam int NUM_W       = bic_pkg::IRQ_W + 1;
    localparam logic [NUM_W-1:0] BANK2_BASE = NUM_W'(BANK_WIDTH);
    localparam logic [NUM_W-1:0] BASIC_BASE = NUM_W'(2 * BANK_WIDTH);
    localparam logic [NUM_W-1:0] BASIC_END  = NUM_W'(2 * BANK_WIDTH + BASIC_WIDTH);

    logic [BANK_WIDTH-1:0]  mask_bank1_reg, mask_bank1_next;
    logic [BANK_WIDTH-1:0]  mask_bank2_reg, mask_bank2_next;
    logic [BASIC_WIDTH-1:0] mask_basic_reg, mask_basic_next;
    logic [NUM_W-1:0]       num_ext;
    logic [NUM_W-1:0]       bank_off;
    logic                   in_bank1;
    logic                   in_bank2;
    logic                   in_basic;
    logic [BIT_W-1:0]       bit_idx;
    logic [BASIC_BIT_W-1:0] basic_idx;

    // The bank is found by comparing the source number against the bank
    // boundaries; subtracting the bank base leaves the bit within the bank.
    // Numbers past the basic bank hit no bank at all.
    assign num_ext   = {1'b0, upd.irq_number};
    assign in_bank1  = (num_ext < BANK2_BASE);
    assign in_bank2  = !in_bank1 && (num_ext < BASIC_BASE);
    assign in_basic  = (num_ext >= BASIC_BASE) && (num_ext < BASIC_END);
    assign bank_off  = in_bank1 ? num_ext
                     : (in_bank2 ? (num_ext - BANK2_BASE) : (num_ext - BASIC_BASE));
    assign bit_idx   = BIT_W'(bank_off);
    assign basic_idx = BASIC_BIT_W'(bank_off);

    always_comb
    begin
        mask_bank1_next = mask_bank1_reg;
        mask_bank2_next = mask_bank2_reg;
        mask_basic_next = mask_basic_reg;
        if (upd.fire)
        begin
            if (in_bank1)
            begin
                mask_bank1_next[bit_idx] = upd.set;
            end
            else if (in_bank2)
            begin
                mask_bank2_next[bit_idx] = upd.set;
            end
            else if (in_basic)
            begin
                mask_basic_next[basic_idx] = upd.set;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_bank1_reg <= '0;
            mask_bank2_reg <= '0;
            mask_basic_reg <= '0;
        end
        else
        begin
            mask_bank1_reg <= mask_bank1_next;
            mask_bank2_reg <= mask_bank2_next;
            mask_basic_reg <= mask_basic_next;
        end
    end

    assign mask_bank1 = mask_bank1_reg;
    assign mask_bank2 = mask_bank2_reg;
    assign mask_basic = mask_basic_reg;

endmodule

`default_nettype wire

// ===== rtl/bic_query.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Masks the raw lines with the enables and finds the lowest pending
// source, bank one first, then bank two, then the basic bank.
module bic_query #(
    parameter int BANK_WIDTH  = bic_pkg::DEFAULT_BANK_WIDTH,
    parameter int BASIC_WIDTH = bic_pkg::DEFAULT_BASIC_WIDTH
) (
    input  wire bic_pkg::req_t          item,
    input  wire logic [BANK_WIDTH-1:0]  mask_bank1,
    input  wire logic [BANK_WIDTH-1:0]  mask_bank2,
    input  wire logic [BASIC_WIDTH-1:0] mask_basic,
    output bic_pkg::rsp_t               result
);

    localparam int ID_W = bic_pkg::ID_W;

    logic [bic_pkg::RAW_W-1:0] pend1, pend2, pendb;

    // Isolate the lowest set bit, then encode the one-hot word.
    function automatic logic [bic_pkg::RAW_IDX_W-1:0] lowest_idx(
        input logic [bic_pkg::RAW_W-1:0] v
    );
        logic [bic_pkg::RAW_W-1:0]     onehot;
        logic [bic_pkg::RAW_IDX_W-1:0] idx;
        onehot = v & (~v + bic_pkg::RAW_W'(1));
        idx    = '0;
        for (int i = 0; i < bic_pkg::RAW_W; i++)
        begin
            if (onehot[i])
            begin
                idx = idx | bic_pkg::RAW_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    assign pend1 = bic_pkg::RAW_W'(item.raw_lines_bank1[BANK_WIDTH-1:0] & mask_bank1);
    assign pend2 = bic_pkg::RAW_W'(item.raw_lines_bank2[BANK_WIDTH-1:0] & mask_bank2);
    assign pendb = bic_pkg::RAW_W'(item.raw_lines_basic[BASIC_WIDTH-1:0] & mask_basic);

    always_comb
    begin
        result.found     = 1'b0;
        result.source_id = '0;
        if (pend1 != '0)
        begin
            result.found     = 1'b1;
            result.source_id = ID_W'(lowest_idx(pend1));
        end
        else if (pend2 != '0)
        begin
            result.found     = 1'b1;
            result.source_id = ID_W'(lowest_idx(pend2)) + ID_W'(BANK_WIDTH);
        end
        else if (pendb != '0)
        begin
            result.found     = 1'b1;
            result.source_id = ID_W'(lowest_idx(pendb)) + ID_W'(2 * BANK_WIDTH);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/banked_interrupt_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Banked interrupt controller. Sources 0 to BANK_WIDTH-1 form bank one,
// the next BANK_WIDTH sources form bank two, and the following
// BASIC_WIDTH sources form the basic bank; each bank has an enable mask
// that clears to zero at reset. A request beat either enables or disables
// one source by number (numbers past the basic bank are ignored), or
// queries: the raw lines carried in the beat are ANDed with the enables
// and the lowest pending source is returned, bank one first, with found
// low and an id of zero when nothing is pending. Only queries produce a
// response beat; enable, disable and the unused operation code produce
// none. The block accepts one request beat every clock cycle unless a
// query is held back by a response that has not been taken. A request
// passes through an input register, where the enable update or the
// masking and priority encode is done, and a query result lands in an
// output register, from which the response beat is offered. Updates and
// queries are applied in arrival order, so a query always sees every
// earlier enable and disable. When a response waits in the output
// register and the next query is ready behind it, the request side
// stalls until the response beat is taken.
module banked_interrupt_controller #(
    parameter int BANK_WIDTH  = bic_pkg::DEFAULT_BANK_WIDTH,
    parameter int BASIC_WIDTH = bic_pkg::DEFAULT_BASIC_WIDTH
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bic_req_if.sink     req,
    bic_rsp_if.source   rsp
);

    logic                   s1_valid;
    bic_pkg::req_t          s1_item;
    logic                   s1_advance;
    logic                   s1_is_query;
    logic                   s1_is_update;
    bic_pkg::upd_t          upd;
    bic_pkg::rsp_t          q_result;
    logic [BANK_WIDTH-1:0]  mask_bank1;
    logic [BANK_WIDTH-1:0]  mask_bank2;
    logic [BASIC_WIDTH-1:0] mask_basic;

    logic                   out_valid_reg, out_valid_next;
    bic_pkg::rsp_t          out_data_reg;

    bic_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .advance (s1_advance),
        .valid   (s1_valid),
        .item    (s1_item)
    );

    // Decode the held beat. The unused operation code falls through and
    // simply retires.
    always_comb
    begin
        s1_is_query  = 1'b0;
        s1_is_update = 1'b0;
        unique case (s1_item.operation)
            bic_pkg::OP_ENABLE,
            bic_pkg::OP_DISABLE:
            begin
                s1_is_update = 1'b1;
            end
            bic_pkg::OP_QUERY:
            begin
                s1_is_query = 1'b1;
            end
            default:
            begin
                s1_is_query  = 1'b0;
                s1_is_update = 1'b0;
            end
        endcase
    end

    // Only a query needs room in the output register.
    assign s1_advance = s1_valid && (!s1_is_query || !out_valid_reg || rsp.ready);

    assign upd.fire       = s1_advance && s1_is_update;
    assign upd.set        = (s1_item.operation == bic_pkg::OP_ENABLE);
    assign upd.irq_number = s1_item.irq_number;

    bic_enable_regs #(
        .BANK_WIDTH  (BANK_WIDTH),
        .BASIC_WIDTH (BASIC_WIDTH)
    ) u_enable_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (upd),
        .mask_bank1 (mask_bank1),
        .mask_bank2 (mask_bank2),
        .mask_basic (mask_basic)
    );

    bic_query #(
        .BANK_WIDTH  (BANK_WIDTH),
        .BASIC_WIDTH (BASIC_WIDTH)
    ) u_query (
        .item       (s1_item),
        .mask_bank1 (mask_bank1),
        .mask_bank2 (mask_bank2),
        .mask_basic (mask_basic),
        .result     (q_result)
    );

    // Output register: loads a query result, empties when the beat is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance && s1_is_query)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_is_query)
        begin
            out_data_reg <= q_result;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.found     = out_data_reg.found;
    assign rsp.source_id = out_data_reg.source_id;

endmodule

`default_nettype wire
